### hdl/xpbd_pkg.sv
// Package: types, constants and codes for the XPBD distance constraint solver.
package xpbd_pkg;

  localparam int PARTICLE_COUNT = 1024;
  localparam int ADDR_W = $clog2(PARTICLE_COUNT);

  localparam int SQ_STEPS = 33;
  localparam int ROOT_STEPS = 34;
  localparam int DIV_STEPS = 31;
  localparam int MUL_STEPS = 34;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_PROJECT = 2'd1,
    OP_READ = 2'd2,
    OP_NOP = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_APPLIED = 2'd1,
    ST_IMMOVABLE = 2'd2,
    ST_COINCIDENT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_LOAD, S_SQ, S_SUM, S_SQRT, S_PREP,
    S_DIV, S_GSET, S_MMUL, S_USET, S_UMUL, S_WRA, S_WRB
  } state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [9:0] index_a;
    logic [9:0] index_b;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0] inverse_mass;
    logic [31:0] rest_length;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic signed [31:0] read_x;
    logic signed [31:0] read_y;
    logic signed [31:0] read_z;
    logic [31:0] read_inverse_mass;
  } result_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [31:0] w;
  } particle_t;

endpackage

### hdl/xpbd_distance_constraint_solver.sv
// Top level: particle store with write, read and XPBD distance constraint projection.
// A command is taken when start is high and busy is low; its result appears on result for
// exactly one cycle with done high and cannot be held off. Write and no-op commands answer in
// the next cycle with busy staying low, a read answers once S_READ has passed, and a projection
// whose particles are both immovable or coincident answers from S_LOAD; any other projection
// reads both particles from the single particle memory, squares the three axis distances on
// bit-serial multipliers, takes the square root one bit a cycle, runs five restoring dividers
// in parallel, then two rounds of bit-serial multiplication, and writes the two particles back
// through the memory's one write port. alpha_tilde is written with cfg_write.
module xpbd_distance_constraint_solver (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  xpbd_pkg::cmd_t      cmd,
  output logic                done,
  output xpbd_pkg::result_t   result,
  input  logic                cfg_write,
  input  logic [31:0]         cfg_data
);

  xpbd_pkg::particle_t mem [xpbd_pkg::PARTICLE_COUNT];
  xpbd_pkg::particle_t rd_a, rd_b;

  xpbd_pkg::state_t state, state_next;
  logic [5:0] cnt;
  logic [31:0] alpha_tilde;
  logic [xpbd_pkg::ADDR_W-1:0] addr_a, addr_b;
  logic [31:0] rest;

  logic accept;
  logic wr_en;
  logic [xpbd_pkg::ADDR_W-1:0] wr_addr, ra, rb;
  xpbd_pkg::particle_t wr_data;

  logic signed [31:0] pa [3];
  logic signed [31:0] pb [3];
  logic [31:0] wa, wb;
  logic [32:0] dmag [3];
  logic [2:0] dneg;

  logic [65:0] mcand [6];
  logic [33:0] mplier [6];
  logic [65:0] acc [6];

  logic [67:0] rad;
  logic [36:0] rem;
  logic [33:0] root;

  logic [33:0] cmag;
  logic cneg;

  logic [34:0] dr [5];
  logic [33:0] dd [5];
  logic [30:0] dq [5];
  logic [4:0] dbit;

  logic last;
  logic [34:0] mv_a [3];
  logic [34:0] mv_b [3];
  logic [2:0] mneg;

  function automatic logic signed [31:0] sat_add(logic signed [31:0] p, logic [34:0] m,
                                                 logic sub);
    logic signed [35:0] s;
    s = sub ? ($signed({{4{p[31]}}, p}) - $signed({1'b0, m}))
            : ($signed({{4{p[31]}}, p}) + $signed({1'b0, m}));
    if (s > 36'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (s < -36'sd2147483648) begin
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  assign accept = start && !busy;

  always_comb begin
    unique case (state) inside
      xpbd_pkg::S_SQ:   last = (cnt == 6'(xpbd_pkg::SQ_STEPS - 1));
      xpbd_pkg::S_SQRT: last = (cnt == 6'(xpbd_pkg::ROOT_STEPS - 1));
      xpbd_pkg::S_DIV:  last = (cnt == 6'(xpbd_pkg::DIV_STEPS - 1));
      xpbd_pkg::S_MMUL, xpbd_pkg::S_UMUL: last = (cnt == 6'(xpbd_pkg::MUL_STEPS - 1));
      default: last = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      xpbd_pkg::S_IDLE: begin
        if (accept && cmd.opcode == xpbd_pkg::OP_READ) state_next = xpbd_pkg::S_READ;
        else if (accept && cmd.opcode == xpbd_pkg::OP_PROJECT) state_next = xpbd_pkg::S_LOAD;
      end
      xpbd_pkg::S_READ: state_next = xpbd_pkg::S_IDLE;
      xpbd_pkg::S_LOAD: begin
        if ((rd_a.w == 32'd0 && rd_b.w == 32'd0) ||
            (rd_a.x == rd_b.x && rd_a.y == rd_b.y && rd_a.z == rd_b.z)) begin
          state_next = xpbd_pkg::S_IDLE;
        end else begin
          state_next = xpbd_pkg::S_SQ;
        end
      end
      xpbd_pkg::S_SQ:   if (last) state_next = xpbd_pkg::S_SUM;
      xpbd_pkg::S_SUM:  state_next = xpbd_pkg::S_SQRT;
      xpbd_pkg::S_SQRT: if (last) state_next = xpbd_pkg::S_PREP;
      xpbd_pkg::S_PREP: state_next = xpbd_pkg::S_DIV;
      xpbd_pkg::S_DIV:  if (last) state_next = xpbd_pkg::S_GSET;
      xpbd_pkg::S_GSET: state_next = xpbd_pkg::S_MMUL;
      xpbd_pkg::S_MMUL: if (last) state_next = xpbd_pkg::S_USET;
      xpbd_pkg::S_USET: state_next = xpbd_pkg::S_UMUL;
      xpbd_pkg::S_UMUL: if (last) state_next = xpbd_pkg::S_WRA;
      xpbd_pkg::S_WRA:  state_next = xpbd_pkg::S_WRB;
      xpbd_pkg::S_WRB:  state_next = xpbd_pkg::S_IDLE;
      default: state_next = xpbd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mv_a[k] = acc[k][64:30];
      mv_b[k] = acc[k+3][64:30];
      mneg[k] = dneg[k] ^ cneg;
    end
  end

  always_comb begin
    busy = (state != xpbd_pkg::S_IDLE);
    ra = (state == xpbd_pkg::S_IDLE) ? cmd.index_a[xpbd_pkg::ADDR_W-1:0] : addr_a;
    rb = (state == xpbd_pkg::S_IDLE) ? cmd.index_b[xpbd_pkg::ADDR_W-1:0] : addr_b;
    wr_en = 1'b0;
    wr_addr = addr_a;
    wr_data = '{x: cmd.pos_x, y: cmd.pos_y, z: cmd.pos_z, w: cmd.inverse_mass};
    unique case (state)
      xpbd_pkg::S_IDLE: begin
        wr_en = accept && cmd.opcode == xpbd_pkg::OP_WRITE;
        wr_addr = cmd.index_a[xpbd_pkg::ADDR_W-1:0];
      end
      xpbd_pkg::S_WRA: begin
        wr_en = 1'b1;
        wr_data = '{x: sat_add(pa[0], mv_a[0], mneg[0]),
                    y: sat_add(pa[1], mv_a[1], mneg[1]),
                    z: sat_add(pa[2], mv_a[2], mneg[2]), w: wa};
      end
      xpbd_pkg::S_WRB: begin
        wr_en = 1'b1;
        wr_addr = addr_b;
        wr_data = '{x: sat_add(pb[0], mv_b[0], !mneg[0]),
                    y: sat_add(pb[1], mv_b[1], !mneg[1]),
                    z: sat_add(pb[2], mv_b[2], !mneg[2]), w: wb};
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xpbd_pkg::S_IDLE;
      cnt <= '0;
      done <= 1'b0;
      alpha_tilde <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) alpha_tilde <= cfg_data;
      if (state_next != state || last || state == xpbd_pkg::S_IDLE) cnt <= '0;
      else cnt <= cnt + 6'd1;
      unique case (state)
        xpbd_pkg::S_IDLE: done <= accept && (cmd.opcode == xpbd_pkg::OP_WRITE ||
                                             cmd.opcode == xpbd_pkg::OP_NOP);
        xpbd_pkg::S_READ: done <= 1'b1;
        xpbd_pkg::S_LOAD: done <= (state_next == xpbd_pkg::S_IDLE);
        xpbd_pkg::S_WRB:  done <= 1'b1;
        default: done <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state) inside
      xpbd_pkg::S_IDLE: begin
        addr_a <= cmd.index_a[xpbd_pkg::ADDR_W-1:0];
        addr_b <= cmd.index_b[xpbd_pkg::ADDR_W-1:0];
        rest <= cmd.rest_length;
        result <= '{status: xpbd_pkg::ST_DONE, default: '0};
      end
      xpbd_pkg::S_READ: begin
        result <= '{status: xpbd_pkg::ST_DONE, read_x: rd_a.x, read_y: rd_a.y,
                    read_z: rd_a.z, read_inverse_mass: rd_a.w};
      end
      xpbd_pkg::S_LOAD: begin
        logic signed [32:0] d [3];
        logic signed [31:0] qa [3];
        logic signed [31:0] qb [3];
        qa[0] = rd_a.x; qa[1] = rd_a.y; qa[2] = rd_a.z;
        qb[0] = rd_b.x; qb[1] = rd_b.y; qb[2] = rd_b.z;
        wa <= rd_a.w;
        wb <= rd_b.w;
        for (int k = 0; k < 3; k++) begin
          d[k] = $signed({qb[k][31], qb[k]}) - $signed({qa[k][31], qa[k]});
          pa[k] <= qa[k];
          pb[k] <= qb[k];
          dneg[k] <= d[k][32];
          dmag[k] <= d[k][32] ? 33'(-d[k]) : 33'(d[k]);
          mcand[k] <= 66'(d[k][32] ? 33'(-d[k]) : 33'(d[k]));
          mplier[k] <= 34'(d[k][32] ? 33'(-d[k]) : 33'(d[k]));
          acc[k] <= '0;
        end
        if (rd_a.w == 32'd0 && rd_b.w == 32'd0) begin
          result <= '{status: xpbd_pkg::ST_IMMOVABLE, default: '0};
        end else begin
          result <= '{status: xpbd_pkg::ST_COINCIDENT, default: '0};
        end
      end
      xpbd_pkg::S_SQ, xpbd_pkg::S_MMUL, xpbd_pkg::S_UMUL: begin
        for (int k = 0; k < 6; k++) begin
          if (mplier[k][0]) acc[k] <= acc[k] + mcand[k];
          mcand[k] <= {mcand[k][64:0], 1'b0};
          mplier[k] <= {1'b0, mplier[k][33:1]};
        end
      end
      xpbd_pkg::S_SUM: begin
        rad <= 68'(acc[0]) + 68'(acc[1]) + 68'(acc[2]);
        rem <= '0;
        root <= '0;
      end
      xpbd_pkg::S_SQRT: begin
        logic [36:0] t;
        logic [36:0] trial;
        t = {rem[34:0], rad[67:66]};
        trial = {1'b0, root, 2'b01};
        if (t >= trial) begin
          rem <= t - trial;
          root <= {root[32:0], 1'b1};
        end else begin
          rem <= t;
          root <= {root[32:0], 1'b0};
        end
        rad <= {rad[65:0], 2'b00};
      end
      xpbd_pkg::S_PREP: begin
        logic [33:0] denom;
        denom = 34'(wa) + 34'(wb) + 34'(alpha_tilde);
        cneg <= root < 34'(rest);
        cmag <= (root < 34'(rest)) ? 34'(rest) - root : root - 34'(rest);
        dr[0] <= 35'(wa[31:1]);
        dr[1] <= 35'(wb[31:1]);
        dd[0] <= denom;
        dd[1] <= denom;
        dbit[0] <= wa[0];
        dbit[1] <= wb[0];
        for (int k = 0; k < 3; k++) begin
          dr[k+2] <= 35'(dmag[k][32:1]);
          dd[k+2] <= root;
          dbit[k+2] <= dmag[k][0];
        end
      end
      xpbd_pkg::S_DIV: begin
        for (int k = 0; k < 5; k++) begin
          logic [34:0] t;
          t = {dr[k][33:0], (cnt == 6'd0) ? dbit[k] : 1'b0};
          if (t >= 35'(dd[k])) begin
            dr[k] <= t - 35'(dd[k]);
            dq[k] <= {dq[k][29:0], 1'b1};
          end else begin
            dr[k] <= t;
            dq[k] <= {dq[k][29:0], 1'b0};
          end
        end
      end
      xpbd_pkg::S_GSET: begin
        for (int k = 0; k < 2; k++) begin
          mcand[k] <= 66'(cmag);
          mplier[k] <= 34'(dq[k]);
          acc[k] <= '0;
        end
      end
      xpbd_pkg::S_USET: begin
        for (int k = 0; k < 3; k++) begin
          mcand[k] <= 66'(acc[0][63:30]);
          mcand[k+3] <= 66'(acc[1][63:30]);
          mplier[k] <= 34'(dq[k+2]);
          mplier[k+3] <= 34'(dq[k+2]);
          acc[k] <= '0;
          acc[k+3] <= '0;
        end
      end
      xpbd_pkg::S_WRB: begin
        result <= '{status: xpbd_pkg::ST_APPLIED, default: '0};
      end
      default: begin
        rest <= rest;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.opcode == xpbd_pkg::OP_PROJECT) |=> (state == xpbd_pkg::S_LOAD))
    else $error("projection did not start");
  assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.opcode == xpbd_pkg::OP_WRITE) |=> (done && !busy))
    else $error("write transfer not answered");
  assert property (@(posedge clk) disable iff (rst) cnt < 6'(xpbd_pkg::MUL_STEPS))
    else $error("step counter overrun");

endmodule
